[design/csv_field_tokenizer_assert.svh]
// Assertion macros for the CSV field tokenizer.
// Used by the top level; needs a clock named clk and a reset named rst_n in scope.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CSVT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CSVT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSVT_ASSERT_IMPL(name, ante, cons, msg)
`define CSVT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

[design/csvt_pkg.sv]
// Shared types and constants of the CSV field tokenizer.
// Used by every module of the block; depends on nothing.
package csvt_pkg;

    // Special byte values.
    localparam logic [7:0] QUOTE_BYTE   = 8'd34;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] SEP_RESET    = 8'd44;

    // Widest header the tokenizer keeps.
    localparam logic [5:0] MAX_COLUMNS = 6'd32;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END  = 2'd2;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Input transaction.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_stream;
    } csvt_in_t;

    // Output transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic [4:0] column;
        logic       is_header;
        logic       last;
    } csvt_out_t;

    // Command from front to back: one result, or a padding run of cell ends
    // from col up to end_col where the last one closes the row.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
        logic [5:0] col;
        logic [5:0] end_col;
        logic       is_header;
        logic       pad;
    } csvt_cmd_t;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic      valid;
        csvt_cmd_t cmd;
    } csvt_head_t;

endpackage

[design/csv_field_tokenizer.sv]
// CSV field tokenizer, top level.
// Channels: in_valid / in_stall / in_data carry one text byte (or an end of
// stream mark) per transaction; out_valid / out_stall / out_data carry one
// result per transaction: a cell byte, a cell end or a row end, with its
// column, a header flag and a last flag on the final result of each input.
// cfg_write / cfg_data set the separator byte (44 after reset).
// Throughput: one input byte per cycle while the queue is not full. A byte
// gives at most one result; a record end on a short data row gives one result
// per missing column plus the row end, and the back end issues one of those
// per cycle unless the receiver stalls. Each result passes through the
// four-entry command queue between the front and back ends and then the
// output register. in_stall rises only when that queue is full, so an output
// stall backs up into the input after four pending commands. Stalled results
// stay in the output register unchanged.
// Reset clears the quote and cell state, the header and row width, and
// empties the queue and the output register.
// Depends on csvt_pkg and csv_field_tokenizer_assert.svh.
`include "csv_field_tokenizer_assert.svh"

module csv_field_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  csvt_pkg::csvt_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output csvt_pkg::csvt_out_t out_data,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_data
);
    import csvt_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    csvt_cmd_t  q_cmd;
    csvt_head_t q_head;

    // Front end: classification and state.
    csvt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .queue_full (q_full),
        .push       (q_push),
        .cmd        (q_cmd)
    );

    // Command queue.
    csvt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    // Back end: result expansion and output register.
    csvt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A row end is always the final result of its input.
    `CSVT_ASSERT_IMPL(a_row_end_last, out_valid && (out_data.out_kind == KIND_ROW_END), out_data.last, "row end without last")

    // Only padding cell ends are followed by more results of the same input.
    `CSVT_ASSERT_IMPL(a_not_last_is_pad, out_valid && !out_data.last, out_data.out_kind == KIND_CELL_END, "non-final result is not a cell end")

    // A padding run moves on to the next column in the very next cycle.
    `CSVT_ASSERT_NEXT(a_pad_advance, out_valid && !out_stall && !out_data.last, out_valid && (out_data.column == ($past(out_data.column) + 5'd1)), "padding run broke")

endmodule

[design/csvt_queue.sv]
// Short command queue that decouples the tokenizer front from its back end.
// Depends on csvt_pkg for the command type and depth.
module csvt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csvt_pkg::csvt_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output csvt_pkg::csvt_head_t head
);
    import csvt_pkg::*;

    csvt_cmd_t           mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    // Status toward both sides.
    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/csvt_front.sv]
// Front end of the CSV field tokenizer: takes bytes, tracks quoting, cells
// and rows, and turns each transaction into at most one command.
// Depends on csvt_pkg.
module csvt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  csvt_pkg::csvt_in_t  in_data,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_data,
    input  logic                queue_full,
    output logic                push,
    output csvt_pkg::csvt_cmd_t cmd
);
    import csvt_pkg::*;

    logic [7:0] separator_reg;
    logic       in_quote_reg, in_quote_next;
    logic       cqs_reg, cqs_next;
    logic       quoted_reg, quoted_next;
    logic       has_bytes_reg, has_bytes_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       skip_reg, skip_next;
    logic [5:0] col_count_reg, col_count_next;
    logic [5:0] row_width_reg, row_width_next;
    logic       header_done_reg, header_done_next;
    logic       pending_reg, pending_next;

    logic       accept;
    logic       do_record;
    logic       is_quote;
    logic       is_sep;
    logic       quote_exit;
    logic       in_quote_eff;
    logic       quoted_eff;
    logic       do_cell;
    logic       put_en;
    logic [7:0] put_byte;
    logic [5:0] lim;
    logic [5:0] lim_fix;
    logic [5:0] c_final;
    logic       emit;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = emit;

    // Separator register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEP_RESET;
        end
        else if (cfg_write)
        begin
            separator_reg <= cfg_data;
        end
    end

    // Classification of one byte and the state update it causes.
    always_comb
    begin
        in_quote_next    = in_quote_reg;
        cqs_next         = cqs_reg;
        quoted_next      = quoted_reg;
        has_bytes_next   = has_bytes_reg;
        held_valid_next  = held_valid_reg;
        held_byte_next   = held_byte_reg;
        skip_next        = skip_reg;
        col_count_next   = col_count_reg;
        row_width_next   = row_width_reg;
        header_done_next = header_done_reg;
        pending_next     = pending_reg;

        emit          = 1'b0;
        cmd           = '0;
        cmd.is_header = !header_done_reg;
        put_en        = 1'b0;
        put_byte      = in_data.char_byte;
        do_cell       = 1'b0;
        c_final       = col_count_reg;

        lim          = header_done_reg ? row_width_reg : MAX_COLUMNS;
        lim_fix      = (lim == '0) ? 6'd1 : lim;
        is_quote     = (in_data.char_byte == QUOTE_BYTE);
        is_sep       = (in_data.char_byte == separator_reg);
        quote_exit   = in_quote_reg && !is_quote && cqs_reg;
        in_quote_eff = in_quote_reg && !quote_exit;
        quoted_eff   = has_bytes_reg && quoted_reg;
        do_record    = in_data.end_of_stream ? pending_reg
                                             : (in_data.char_byte == NEWLINE_BYTE);

        if (accept && do_record)
        begin
            // Record end: one row end, or a padding run up to the row width.
            emit = 1'b1;
            if (({1'b0, col_count_reg} + 7'd1) >= {1'b0, lim_fix})
            begin
                cmd.kind = KIND_ROW_END;
                cmd.col  = lim_fix - 6'd1;
                c_final  = lim_fix - 6'd1;
            end
            else if (!header_done_reg)
            begin
                cmd.kind = KIND_ROW_END;
                cmd.col  = col_count_reg;
            end
            else
            begin
                cmd.pad     = 1'b1;
                cmd.col     = col_count_reg;
                cmd.end_col = lim_fix - 6'd1;
                c_final     = lim_fix - 6'd1;
            end
            if (!header_done_reg)
            begin
                row_width_next   = c_final + 6'd1;
                header_done_next = 1'b1;
            end
            in_quote_next   = 1'b0;
            cqs_next        = 1'b0;
            quoted_next     = 1'b0;
            has_bytes_next  = 1'b0;
            held_valid_next = 1'b0;
            held_byte_next  = '0;
            skip_next       = 1'b0;
            col_count_next  = '0;
            pending_next    = 1'b0;
        end
        else if (accept && !in_data.end_of_stream)
        begin
            pending_next = 1'b1;
            // Quote tracking; a quote byte always counts as cell content.
            if (is_quote)
            begin
                in_quote_next = 1'b1;
                cqs_next      = in_quote_reg ? !cqs_reg : cqs_reg;
                do_cell       = 1'b1;
            end
            else
            begin
                in_quote_next = in_quote_eff;
                if (quote_exit)
                begin
                    cqs_next = 1'b0;
                end
                if (is_sep && !in_quote_eff)
                begin
                    // Cell end outside quotes.
                    if (({1'b0, col_count_reg} + 7'd1) < {1'b0, lim})
                    begin
                        emit     = 1'b1;
                        cmd.kind = KIND_CELL_END;
                        cmd.col  = col_count_reg;
                    end
                    if (col_count_reg != 6'd63)
                    begin
                        col_count_next = col_count_reg + 6'd1;
                    end
                    quoted_next     = 1'b0;
                    has_bytes_next  = 1'b0;
                    held_valid_next = 1'b0;
                    held_byte_next  = '0;
                    skip_next       = 1'b0;
                end
                else
                begin
                    do_cell = 1'b1;
                end
            end

            // Cell content, with unescaping through the one-byte hold.
            if (do_cell)
            begin
                has_bytes_next = 1'b1;
                if (!has_bytes_reg && is_quote)
                begin
                    quoted_next     = 1'b1;
                    skip_next       = 1'b1;
                    held_byte_next  = in_data.char_byte;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    quoted_next = quoted_eff;
                    if (!quoted_eff)
                    begin
                        put_en = 1'b1;
                    end
                    else
                    begin
                        if (held_valid_reg)
                        begin
                            if (skip_reg)
                            begin
                                skip_next = 1'b0;
                            end
                            else
                            begin
                                if (held_byte_reg == QUOTE_BYTE)
                                begin
                                    skip_next = 1'b1;
                                end
                                put_en   = 1'b1;
                                put_byte = held_byte_reg;
                            end
                        end
                        held_byte_next  = in_data.char_byte;
                        held_valid_next = 1'b1;
                    end
                end
            end

            // Content bytes of cells beyond the width are dropped.
            if (put_en && (col_count_reg < lim))
            begin
                emit          = 1'b1;
                cmd.kind      = KIND_BYTE;
                cmd.data_byte = put_byte;
                cmd.col       = col_count_reg;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg    <= 1'b0;
            cqs_reg         <= 1'b0;
            quoted_reg      <= 1'b0;
            has_bytes_reg   <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_byte_reg   <= '0;
            skip_reg        <= 1'b0;
            col_count_reg   <= '0;
            row_width_reg   <= '0;
            header_done_reg <= 1'b0;
            pending_reg     <= 1'b0;
        end
        else
        begin
            in_quote_reg    <= in_quote_next;
            cqs_reg         <= cqs_next;
            quoted_reg      <= quoted_next;
            has_bytes_reg   <= has_bytes_next;
            held_valid_reg  <= held_valid_next;
            held_byte_reg   <= held_byte_next;
            skip_reg        <= skip_next;
            col_count_reg   <= col_count_next;
            row_width_reg   <= row_width_next;
            header_done_reg <= header_done_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

[design/csvt_back.sv]
// Back end of the CSV field tokenizer: expands queued commands into results
// and holds them in the output register while the receiver stalls.
// Depends on csvt_pkg.
module csvt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csvt_pkg::csvt_head_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output csvt_pkg::csvt_out_t  out_data
);
    import csvt_pkg::*;

    logic       out_valid_reg, out_valid_next;
    csvt_out_t  out_data_reg, out_data_next;
    logic       in_run_reg, in_run_next;
    logic [5:0] run_col_reg, run_col_next;

    logic       load;
    logic [5:0] cur_col;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign load      = !out_valid_reg || !out_stall;
    assign cur_col   = in_run_reg ? run_col_reg : head.cmd.col;

    // One result per cycle from the queue head while the receiver does not stall.
    always_comb
    begin
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        in_run_next    = in_run_reg;
        run_col_next   = run_col_reg;
        if (load)
        begin
            out_valid_next          = head.valid;
            out_data_next.is_header = head.cmd.is_header;
            if (!head.cmd.pad)
            begin
                out_data_next.out_byte = head.cmd.data_byte;
                out_data_next.out_kind = head.cmd.kind;
                out_data_next.column   = head.cmd.col[4:0];
                out_data_next.last     = 1'b1;
                pop                    = head.valid;
            end
            else
            begin
                // Padding run: cell ends, then the row end at the last column.
                out_data_next.out_byte = '0;
                out_data_next.column   = cur_col[4:0];
                if (cur_col == head.cmd.end_col)
                begin
                    out_data_next.out_kind = KIND_ROW_END;
                    out_data_next.last     = 1'b1;
                    pop                    = head.valid;
                    if (head.valid)
                    begin
                        in_run_next = 1'b0;
                    end
                end
                else
                begin
                    out_data_next.out_kind = KIND_CELL_END;
                    out_data_next.last     = 1'b0;
                    if (head.valid)
                    begin
                        in_run_next  = 1'b1;
                        run_col_next = cur_col + 6'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            in_run_reg    <= 1'b0;
            run_col_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            in_run_reg    <= in_run_next;
            run_col_reg   <= run_col_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

[dv/csv_field_tokenizer_tb.sv]
// Self-checking testbench for the CSV field tokenizer.
// Streams text bytes with random gaps and output stalls, predicts every cell byte,
// cell end and row end, and checks them in order. Depends on csvt_pkg and the top level.
module testbench;
    import csvt_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 10;
    localparam int RANDOM_PER_PHASE = 20;
    localparam int NUM_PHASES       = 8;
    localparam int MAX_STEP_TOKENS  = 32;

    // Tokenizer state mirror and the queue of tokens still owed by the block.
    class token_scoreboard;
        logic [7:0]  separator;
        bit          in_quote, closing_seen, quoted_cell, cell_started;
        bit          held_valid, skip_next, header_done, line_pending;
        logic [7:0]  held_byte;
        int unsigned col_index, row_width;
        csvt_out_t   step_tokens[$];
        csvt_out_t   tokens_due[$];
        int          mismatches;
        int          tokens_checked;

        function new();
            separator    = SEP_RESET;
            in_quote     = 1'b0;
            closing_seen = 1'b0;
            header_done  = 1'b0;
            line_pending = 1'b0;
            col_index    = 0;
            row_width    = 0;
            mismatches   = 0;
            tokens_checked = 0;
            clear_cell();
        endfunction

        function void clear_cell();
            quoted_cell  = 1'b0;
            cell_started = 1'b0;
            held_valid   = 1'b0;
            held_byte    = 8'd0;
            skip_next    = 1'b0;
        endfunction

        function int unsigned col_limit();
            return header_done ? row_width : int'(MAX_COLUMNS);
        endfunction

        // One token of the current input; the block gives at most 32 per input.
        function void emit_token(logic [7:0] b, logic [1:0] kind, int unsigned col);
            csvt_out_t t;
            t.out_byte  = (kind == KIND_BYTE) ? b : 8'd0;
            t.out_kind  = kind;
            t.column    = 5'(col);
            t.is_header = !header_done;
            t.last      = 1'b0;
            if (step_tokens.size() < MAX_STEP_TOKENS)
                step_tokens.insert(step_tokens.size(), t);
        endfunction

        // Content bytes of cells past the width limit are dropped.
        function void put_content(logic [7:0] b);
            if (col_index < col_limit())
                emit_token(b, KIND_BYTE, col_index);
        endfunction

        // Quoted cells go through a one-byte hold so the closing quote can be dropped.
        function void add_cell_byte(logic [7:0] b);
            if (!cell_started)
            begin
                cell_started = 1'b1;
                if (b == QUOTE_BYTE)
                begin
                    quoted_cell = 1'b1;
                    skip_next   = 1'b1;
                    held_byte   = b;
                    held_valid  = 1'b1;
                    return;
                end
                quoted_cell = 1'b0;
            end
            if (!quoted_cell)
            begin
                put_content(b);
                return;
            end
            if (held_valid)
            begin
                if (skip_next)
                begin
                    skip_next = 1'b0;
                end
                else
                begin
                    if (held_byte == QUOTE_BYTE)
                        skip_next = 1'b1;
                    put_content(held_byte);
                end
            end
            held_byte  = b;
            held_valid = 1'b1;
        endfunction

        // Record end: pads short data rows, and the header row fixes the width.
        function void close_record();
            int unsigned lim;
            int unsigned c;
            lim = col_limit();
            c   = col_index;
            if (lim == 0)
                lim = 1;
            if (c + 1 >= lim)
            begin
                emit_token(8'd0, KIND_ROW_END, lim - 1);
                c = lim - 1;
            end
            else if (!header_done)
            begin
                emit_token(8'd0, KIND_ROW_END, c);
            end
            else
            begin
                for (int unsigned k = c; k + 1 < lim; k++)
                    emit_token(8'd0, KIND_CELL_END, k);
                emit_token(8'd0, KIND_ROW_END, lim - 1);
                c = lim - 1;
            end
            if (!header_done)
            begin
                row_width   = c + 1;
                header_done = 1'b1;
            end
            in_quote     = 1'b0;
            closing_seen = 1'b0;
            clear_cell();
            col_index    = 0;
            line_pending = 1'b0;
        endfunction

        // Accepted input transaction: advance the mirror and queue its tokens.
        function void note_input(csvt_in_t d);
            bit        consumed;
            csvt_out_t t;
            step_tokens.delete();
            consumed = 1'b0;
            if (d.end_of_stream)
            begin
                if (line_pending)
                    close_record();
            end
            else if (d.char_byte == NEWLINE_BYTE)
            begin
                close_record();
            end
            else
            begin
                line_pending = 1'b1;
                if (in_quote)
                begin
                    if (d.char_byte == QUOTE_BYTE)
                    begin
                        closing_seen = !closing_seen;
                        add_cell_byte(d.char_byte);
                        consumed = 1'b1;
                    end
                    else if (closing_seen)
                    begin
                        closing_seen = 1'b0;
                        in_quote     = 1'b0;
                    end
                end
                if (!consumed)
                begin
                    if (d.char_byte == QUOTE_BYTE)
                    begin
                        in_quote = 1'b1;
                        add_cell_byte(d.char_byte);
                    end
                    else if (d.char_byte == separator && !in_quote)
                    begin
                        if (col_index + 1 < col_limit())
                            emit_token(8'd0, KIND_CELL_END, col_index);
                        if (col_index < 63)
                            col_index++;
                        clear_cell();
                    end
                    else
                    begin
                        add_cell_byte(d.char_byte);
                    end
                end
            end
            if (step_tokens.size() > 0)
            begin
                t = step_tokens.pop_back();
                t.last = 1'b1;
                step_tokens.insert(step_tokens.size(), t);
            end
            foreach (step_tokens[i])
                tokens_due.insert(tokens_due.size(), step_tokens[i]);
        endfunction

        // Accepted output transaction: compare with the oldest token owed.
        function void check_result(csvt_out_t got);
            csvt_out_t want;
            if (tokens_due.size() == 0)
            begin
                $error("unexpected result: out_byte %0d out_kind %0d column %0d",
                       got.out_byte, got.out_kind, got.column);
                mismatches++;
                return;
            end
            want = tokens_due.pop_front();
            tokens_checked++;
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.out_kind !== want.out_kind)
            begin
                $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
                mismatches++;
            end
            if (got.column !== want.column)
            begin
                $error("column: expected %0d, actual %0d", want.column, got.column);
                mismatches++;
            end
            if (got.is_header !== want.is_header)
            begin
                $error("is_header: expected %0d, actual %0d", want.is_header, got.is_header);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    csvt_in_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    csvt_out_t  out_data;
    logic       cfg_write = 1'b0;
    logic [7:0] cfg_data  = 8'd0;

    token_scoreboard board = new();
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int items_sent   = 0;
    int stuck_cycles = 0;

    csv_field_tokenizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver stalls at random.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Observe every transaction and register write; a watchdog ends a hung run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                board.separator = cfg_data;
            if (in_valid && !in_stall)
                board.note_input(in_data);
            if (out_valid && !out_stall)
                board.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Present one input transaction, with an optional random gap first.
    task automatic send_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{char_byte: b, end_of_stream: eos};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // End of stream carries a random, ignored byte.
    task automatic send_eos();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == NEWLINE_BYTE || b == QUOTE_BYTE || b == board.separator);
        return b;
    endfunction

    // One cell: mostly plain, some quoted with doubled quotes, a few raw noise.
    task automatic send_cell(input int max_len);
        int         len;
        int         style;
        logic [7:0] b;
        len   = $urandom_range(0, max_len);
        style = $urandom_range(0, 9);
        if (style < 3)
        begin
            send_item(QUOTE_BYTE, 1'b0);
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == NEWLINE_BYTE || $urandom_range(0, 4) == 0)
                    b = QUOTE_BYTE;
                send_item(b, 1'b0);
                if (b == QUOTE_BYTE)
                    send_item(QUOTE_BYTE, 1'b0);
            end
            send_item(QUOTE_BYTE, 1'b0);
        end
        else if (style < 9)
        begin
            repeat (len)
                send_item(plain_byte(), 1'b0);
        end
        else
        begin
            repeat (len + 1)
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // One record of cells, closed by a newline or now and then by end of stream.
    task automatic send_row(input int ncells, input int max_len);
        for (int i = 0; i < ncells; i++)
        begin
            if (i > 0)
                send_item(board.separator, 1'b0);
            send_cell(max_len);
        end
        if ($urandom_range(0, 9) == 0)
            send_eos();
        else
            send_item(NEWLINE_BYTE, 1'b0);
    endtask

    // Random records: mostly short rows that get padded, some wider than the header.
    task automatic random_rows(input int budget);
        int first;
        first = items_sent;
        while (items_sent - first < budget)
        begin
            if ($urandom_range(0, 19) == 0)
                send_eos();
            else if ($urandom_range(0, 6) == 0)
                send_row($urandom_range(30, 35), 2);
            else
                send_row($urandom_range(0, 5), 6);
        end
    endtask

    // Wait until every owed token has arrived, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.tokens_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [7:0] sep_plan [NUM_PHASES];
        sep_plan = '{8'd44, 8'd0, 8'd255, QUOTE_BYTE, NEWLINE_BYTE, 8'd59, 8'd9, 8'd0};
        sep_plan[NUM_PHASES - 1] = 8'($urandom_range(0, 255));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 19;
        stall_pct    = 54;

        // Header: an escaped quoted cell, then more cells than the column limit.
        send_item(QUOTE_BYTE, 1'b0);
        send_item("q", 1'b0);
        send_item(QUOTE_BYTE, 1'b0);
        send_item(QUOTE_BYTE, 1'b0);
        send_item("x", 1'b0);
        send_item(QUOTE_BYTE, 1'b0);
        repeat (MAX_COLUMNS) send_item(board.separator, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);

        // Extreme byte values in a short row that gets padded out.
        send_item(8'h00, 1'b0);
        send_item(board.separator, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);

        // Empty record, then a newline inside an open quote.
        send_item(NEWLINE_BYTE, 1'b0);
        send_item(QUOTE_BYTE, 1'b0);
        send_item("a", 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);

        // A quote in mid-cell starts quoting and hides the separator.
        send_item("x", 1'b0);
        send_item(QUOTE_BYTE, 1'b0);
        send_item("y", 1'b0);
        send_item(board.separator, 1'b0);
        send_item("z", 1'b0);
        send_item(QUOTE_BYTE, 1'b0);
        send_item(board.separator, 1'b0);
        send_item("w", 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);

        // End of stream closes a pending line, then finds nothing pending.
        send_item("k", 1'b0);
        send_eos();
        send_eos();

        // Random phases over several separators and idle patterns.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
                write_separator(sep_plan[p]);
            if (p < 3)
            begin
                send_gap_pct = 19;
                stall_pct    = 54;
            end
            else if (p < 6)
            begin
                send_gap_pct = 54;
                stall_pct    = 19;
            end
            else
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            random_rows(RANDOM_PER_PHASE);
        end

        drain();
        $display("Run covered %0d input transactions and %0d checked results over %0d separators,",
                 items_sent, board.tokens_checked, NUM_PHASES);
        $display("with header truncation, row padding, dropped cells and quote escapes.");
        if (board.mismatches == 0 && board.tokens_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
